// ===== design/rv32_pkg.sv =====
// Package for the RV32I instruction executor: item types, opcodes, funct codes.
// No dependencies.
`timescale 1ns / 1ps
package rv32_pkg;

  typedef struct packed {
    logic        op;
    logic [16:0] load_address;
    logic [7:0]  load_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        halted;
    logic [7:0]  exit_value;
    logic        illegal;
  } out_item_t;

  // Front-to-back queue entry.
  typedef struct packed {
    logic        is_step;
    logic [16:0] load_address;
    logic [7:0]  load_byte;
  } cmd_t;

  localparam logic        OP_LOAD = 1'b0;
  localparam logic        OP_STEP = 1'b1;
  localparam logic [6:0]  OPC_REG    = 7'h33;
  localparam logic [6:0]  OPC_IMM    = 7'h13;
  localparam logic [6:0]  OPC_LOAD   = 7'h03;
  localparam logic [6:0]  OPC_STORE  = 7'h23;
  localparam logic [6:0]  OPC_BRANCH = 7'h63;
  localparam logic [6:0]  OPC_LUI    = 7'h37;
  localparam logic [6:0]  OPC_AUIPC  = 7'h17;
  localparam logic [6:0]  OPC_JAL    = 7'h6f;
  localparam logic [6:0]  OPC_JALR   = 7'h67;
  localparam logic [6:0]  F7_BASE    = 7'h00;
  localparam logic [6:0]  F7_ALT     = 7'h20;
  localparam logic [31:0] EXIT_RESET = 32'h0003_0004;
  localparam logic [1:0]  REG_EXIT   = 2'd0;

endpackage

// ===== design/rv32_front.sv =====
// Front end: accepts items and queues them for the back end.
// Depends on rv32_pkg.
`timescale 1ns / 1ps
module rv32_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rv32_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_take,
  output rv32_pkg::cmd_t     q_data
);
  rv32_pkg::cmd_t q_mem [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_data   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr].is_step      <= (in_data.op == rv32_pkg::OP_STEP);
      q_mem[wr_ptr].load_address <= in_data.load_address;
      q_mem[wr_ptr].load_byte    <= in_data.load_byte;
    end
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
endmodule

// ===== design/rv32_back.sv =====
// Back end: register file, pc, byte memory; runs one queued item in a sequence.
// Depends on rv32_pkg.
`timescale 1ns / 1ps
module rv32_back #(
  parameter int MEM_ADDR_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_take,
  input  rv32_pkg::cmd_t      q_data,
  input  logic [31:0]         exit_address,
  output logic                out_valid,
  input  logic                out_stall,
  output rv32_pkg::out_item_t out_data
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_FWAIT = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_MEM   = 4'd4;
  localparam logic [3:0] S_MWAIT = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]  state;
  logic [7:0]  mem [2**MEM_ADDR_BITS];
  logic [31:0] regs [32];
  logic [31:0] pc;
  logic        halt;
  logic [7:0]  exit_byte;
  logic        ill;
  logic [1:0]  bidx;
  logic [1:0]  fidx;
  logic [31:0] inst;
  logic [31:0] mdata;
  logic [31:0] maddr;
  logic [31:0] sdata;
  logic        mwr;
  logic [1:0]  mlast;
  logic [7:0]  rdata;
  logic [MEM_ADDR_BITS-1:0] m_a;
  logic        m_we;
  logic [7:0]  m_wd;
  logic [31:0] ra;
  logic [31:0] rb;
  logic [31:0] res;
  logic        wb;
  logic [31:0] next_pc;
  logic        bad;
  logic [31:0] ea;
  logic        is_mem;
  logic        is_wr;
  logic [1:0]  nbytes_m1;
  logic        inst_load_pending;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] opb;
  logic [4:0]  sh;
  logic        lts;
  logic        ltu;
  logic        take;
  logic [31:0] ldv;

  assign opc   = inst[6:0];
  assign f3    = inst[14:12];
  assign f7    = inst[31:25];
  assign rd    = inst[11:7];
  assign imm_i = {{20{inst[31]}}, inst[31:20]};
  assign imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
  assign imm_b = {{20{inst[31]}}, inst[7], inst[30:25], inst[11:8], 1'b0};
  assign imm_j = {{12{inst[31]}}, inst[19:12], inst[20], inst[30:21], 1'b0};
  assign ra    = regs[inst[19:15]];
  assign rb    = regs[inst[24:20]];
  assign opb   = (opc == rv32_pkg::OPC_REG) ? rb : imm_i;
  assign sh    = opb[4:0];
  assign lts   = $signed(ra) < $signed(opb);
  assign ltu   = ra < opb;
  assign fidx  = bidx - 2'd1;

  always_comb begin
    res     = '0;
    wb      = 1'b0;
    bad     = 1'b0;
    next_pc = pc + 32'd4;
    ea      = ra + imm_i;
    is_mem  = 1'b0;
    is_wr   = 1'b0;
    nbytes_m1 = 2'd0;
    take    = 1'b0;
    case (opc)
      rv32_pkg::OPC_REG, rv32_pkg::OPC_IMM: begin
        wb = 1'b1;
        case (f3)
          3'd0: begin
            if (opc == rv32_pkg::OPC_REG && f7 == rv32_pkg::F7_ALT) res = ra - opb;
            else res = ra + opb;
            if (opc == rv32_pkg::OPC_REG && f7 != rv32_pkg::F7_BASE &&
                f7 != rv32_pkg::F7_ALT) bad = 1'b1;
          end
          3'd1: begin
            res = ra << sh;
            if (f7 != rv32_pkg::F7_BASE) bad = 1'b1;
          end
          3'd5: begin
            if (f7 == rv32_pkg::F7_ALT) res = $unsigned($signed(ra) >>> sh);
            else res = ra >> sh;
            if (f7 != rv32_pkg::F7_BASE && f7 != rv32_pkg::F7_ALT) bad = 1'b1;
          end
          default: begin
            case (f3)
              3'd2:    res = {31'd0, lts};
              3'd3:    res = {31'd0, ltu};
              3'd4:    res = ra ^ opb;
              3'd6:    res = ra | opb;
              default: res = ra & opb;
            endcase
            if (opc == rv32_pkg::OPC_REG && f7 != rv32_pkg::F7_BASE) bad = 1'b1;
          end
        endcase
      end
      rv32_pkg::OPC_LOAD: begin
        is_mem = 1'b1;
        wb     = 1'b1;
        case (f3)
          3'd0, 3'd4: nbytes_m1 = 2'd0;
          3'd1, 3'd5: nbytes_m1 = 2'd1;
          3'd2:       nbytes_m1 = 2'd3;
          default:    bad = 1'b1;
        endcase
      end
      rv32_pkg::OPC_STORE: begin
        ea     = ra + imm_s;
        is_mem = 1'b1;
        is_wr  = 1'b1;
        case (f3)
          3'd0:    nbytes_m1 = 2'd0;
          3'd1:    nbytes_m1 = 2'd1;
          3'd2:    nbytes_m1 = 2'd3;
          default: bad = 1'b1;
        endcase
      end
      rv32_pkg::OPC_BRANCH: begin
        case (f3)
          3'd0:    take = (ra == rb);
          3'd1:    take = (ra != rb);
          3'd4:    take = $signed(ra) < $signed(rb);
          3'd5:    take = !($signed(ra) < $signed(rb));
          3'd6:    take = ra < rb;
          3'd7:    take = ra >= rb;
          default: bad = 1'b1;
        endcase
        if (take) next_pc = pc + imm_b;
      end
      rv32_pkg::OPC_LUI: begin
        wb = 1'b1; res = {inst[31:12], 12'd0};
      end
      rv32_pkg::OPC_AUIPC: begin
        wb = 1'b1; res = pc + {inst[31:12], 12'd0};
      end
      rv32_pkg::OPC_JAL: begin
        wb = 1'b1; res = pc + 32'd4; next_pc = pc + imm_j;
      end
      rv32_pkg::OPC_JALR: begin
        wb = 1'b1; res = pc + 32'd4; next_pc = (ra + imm_i) & ~32'd1;
        if (f3 != 3'd0) bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      wb      = 1'b0;
      is_mem  = 1'b0;
      next_pc = pc + 32'd4;
    end
  end

  always_comb begin
    case (f3)
      3'd0:    ldv = {{24{mdata[7]}}, mdata[7:0]};
      3'd1:    ldv = {{16{mdata[15]}}, mdata[15:0]};
      3'd4:    ldv = {24'd0, mdata[7:0]};
      3'd5:    ldv = {16'd0, mdata[15:0]};
      default: ldv = mdata;
    endcase
  end

  // Single memory port.
  always_comb begin
    m_we = 1'b0;
    m_wd = q_data.load_byte;
    m_a  = MEM_ADDR_BITS'(q_data.load_address);
    if (state == S_IDLE) begin
      m_we = q_valid && !q_data.is_step;
    end else if (state == S_FETCH || state == S_FWAIT) begin
      m_a = MEM_ADDR_BITS'(pc + {30'd0, bidx});
    end else begin
      m_a  = MEM_ADDR_BITS'(maddr + {30'd0, bidx});
      m_we = (state == S_MEM) && mwr;
      m_wd = sdata[8*bidx +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) mem[m_a] <= m_wd;
    rdata <= mem[m_a];
  end

  assign q_take    = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      halt      <= 1'b0;
      exit_byte <= '0;
      ill       <= 1'b0;
      for (int i = 0; i < 32; i++) regs[i] <= '0;
    end else begin
      case (state)
        S_IDLE: if (q_valid) begin
          ill  <= 1'b0;
          bidx <= 2'd0;
          state <= (q_data.is_step && !halt) ? S_FETCH : S_DONE;
        end
        S_FETCH: begin
          bidx  <= bidx + 2'd1;
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          inst[8*fidx +: 8] <= rdata;
          bidx <= bidx + 2'd1;
          if (bidx == 2'd0) state <= S_EXEC;
        end
        S_EXEC: begin
          ill   <= bad;
          maddr <= ea;
          sdata <= rb;
          mwr   <= is_wr;
          mlast <= nbytes_m1;
          mdata <= '0;
          bidx  <= 2'd0;
          if (is_mem) begin
            state <= S_MEM;
          end else begin
            if (wb && rd != 5'd0) regs[rd] <= res;
            pc    <= next_pc;
            state <= S_DONE;
          end
          if (is_wr && !bad && f3 == 3'd0 && ea == exit_address) begin
            halt      <= 1'b1;
            exit_byte <= regs[10][7:0];
          end
        end
        S_MEM: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          mdata[8*bidx +: 8] <= rdata;
          if (bidx == mlast) state <= S_DONE;
          else begin
            bidx  <= bidx + 2'd1;
            state <= S_MEM;
          end
          if (bidx == mlast) begin
            pc <= pc + 32'd4;
            if (!mwr && rd != 5'd0) begin
              regs[rd] <= 32'd0;
            end
          end
        end
        S_DONE: begin
          if (inst_load_pending) regs[rd] <= ldv;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) inst_load_pending <= 1'b0;
    else if (state == S_MWAIT && bidx == mlast) inst_load_pending <= !mwr && rd != 5'd0;
    else if (state == S_DONE) inst_load_pending <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      out_data.pc_after   <= pc;
      out_data.halted     <= halt;
      out_data.exit_value <= exit_byte;
      out_data.illegal    <= ill;
    end
  end

  a_x0_zero: assert property (@(posedge clk) disable iff (rst)
    regs[0] == 32'd0) else $error("x0 written");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(halt) && !$past(rst) |-> halt) else $error("halt cleared");
  a_halt_pc: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && halt && $past(halt) && $past(state) == S_OUT |-> $stable(pc))
    else $error("pc moved after halt");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule

// ===== design/rv32i_instruction_executor_unit.sv =====
// Top level of the RV32I executor: APB register, front queue, back end.
// Depends on rv32_pkg, rv32_front, rv32_back.
//
//   channel | handshake             | payload
//   in      | in_valid / in_stall   | in_data (rv32_pkg::in_item_t)
//   out     | out_valid / out_stall | out_data (rv32_pkg::out_item_t)
//   cfg     | psel/penable/pwrite   | paddr, pwdata, prdata
//
// Load item: S_DONE, then S_OUT with the result. Step: S_FETCH and S_FWAIT (4 fetch
// reads), S_EXEC, S_MEM/S_MWAIT per data byte (1 to 4, single port), S_DONE, S_OUT.
// Reset is synchronous; registers, pc, halt and exit byte clear; memory does not.
// A two-entry queue lets the input take up to two items while a result waits on out_stall.
`timescale 1ns / 1ps
module rv32i_instruction_executor_unit #(
  parameter int MEM_ADDR_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rv32_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rv32_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic           q_valid;
  logic           q_take;
  rv32_pkg::cmd_t q_data;
  logic [31:0]    exit_address;

  assign pready = 1'b1;
  assign prdata = (paddr == rv32_pkg::REG_EXIT) ? exit_address : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) exit_address <= rv32_pkg::EXIT_RESET;
    else if (psel && penable && pwrite && paddr == rv32_pkg::REG_EXIT)
      exit_address <= pwdata;
  end

  rv32_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .q_valid, .q_take, .q_data
  );

  rv32_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_data, .exit_address,
    .out_valid, .out_stall, .out_data
  );
endmodule

// ===== sim/tb_rv32i_instruction_executor_unit.sv =====
// Testbench for the RV32I executor: loads program bytes, steps instructions and checks
// every result against an in-bench instruction-set predictor. Depends on rv32_pkg and the RTL.
`timescale 1ns / 1ps
module tb_rv32i_instruction_executor_unit;

  localparam int          MEM_BYTES = 1 << 17;
  localparam logic [31:0] MEM_MASK  = MEM_BYTES - 1;
  localparam logic [31:0] NOP       = 32'h0000_0013;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rv32_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rv32_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [1:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  rv32i_instruction_executor_unit u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic [7:0]  mem [MEM_BYTES];
  bit          mem_known [MEM_BYTES];
  logic        halt_q;
  logic [7:0]  exit_q;
  logic [31:0] exit_addr_q;

  rv32_pkg::out_item_t pending_results[$];
  int        n_errors = 0;
  int        n_items = 0;
  bit        tx_idle = 1'b0;
  bit        rx_idle = 1'b0;
  int        rx_hold = 0;
  int        rx_wait = 0;
  logic      rx_block = 1'b0;

  task automatic report(input string msg);
    if (n_errors < 30) $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic logic [31:0] mem_read(input logic [31:0] a, input int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = mem[(a + i) & MEM_MASK];
    return v;
  endfunction

  function automatic bit alu_eval(input logic [2:0] f3, input logic [6:0] f7, input bit rform,
                                  input logic [31:0] a, input logic [31:0] b,
                                  output logic [31:0] r);
    logic [4:0] sh;
    sh = b[4:0];
    r = '0;
    if (rform && f7 != rv32_pkg::F7_BASE &&
        !(f7 == rv32_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) return 1'b0;
    case (f3)
      3'd0: r = (rform && f7 == rv32_pkg::F7_ALT) ? a - b : a + b;
      3'd1: begin
        if (f7 != rv32_pkg::F7_BASE) return 1'b0;
        r = a << sh;
      end
      3'd2: r = {31'b0, $signed(a) < $signed(b)};
      3'd3: r = {31'b0, a < b};
      3'd4: r = a ^ b;
      3'd5: begin
        if (f7 == rv32_pkg::F7_BASE) r = a >> sh;
        else if (f7 == rv32_pkg::F7_ALT) r = $signed(a) >>> sh;
        else return 1'b0;
      end
      3'd6: r = a | b;
      default: r = a & b;
    endcase
    return 1'b1;
  endfunction

  function automatic bit iss_execute();
    logic [31:0] inst, a, b, immi, imm, nxt, res, addr, v;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    bit          ok, wb, take;
    inst = mem_read(pc_q, 4);
    opc  = inst[6:0];
    rd   = inst[11:7];
    f3   = inst[14:12];
    a    = gpr[inst[19:15]];
    b    = gpr[inst[24:20]];
    immi = {{20{inst[31]}}, inst[31:20]};
    nxt  = pc_q + 4;
    res  = '0;
    ok   = 1'b1;
    wb   = 1'b1;
    take = 1'b0;
    case (opc)
      rv32_pkg::OPC_REG: ok = alu_eval(f3, inst[31:25], 1'b1, a, b, res);
      rv32_pkg::OPC_IMM: begin
        if (f3 == 3'd1 || f3 == 3'd5)
          ok = alu_eval(f3, inst[31:25], 1'b0, a, {27'b0, inst[24:20]}, res);
        else
          ok = alu_eval(f3, rv32_pkg::F7_BASE, 1'b0, a, immi, res);
      end
      rv32_pkg::OPC_LOAD: begin
        addr = a + immi;
        case (f3)
          3'd0: begin
            v = mem_read(addr, 1);
            res = {{24{v[7]}}, v[7:0]};
          end
          3'd1: begin
            v = mem_read(addr, 2);
            res = {{16{v[15]}}, v[15:0]};
          end
          3'd2: res = mem_read(addr, 4);
          3'd4: res = mem_read(addr, 1);
          3'd5: res = mem_read(addr, 2);
          default: ok = 1'b0;
        endcase
      end
      rv32_pkg::OPC_STORE: begin
        wb = 1'b0;
        if (f3 > 3'd2) ok = 1'b0;
        else begin
          addr = a + {{20{inst[31]}}, inst[31:25], inst[11:7]};
          for (int i = 0; i < (1 << f3); i++) begin
            mem[(addr + i) & MEM_MASK] = b[8*i +: 8];
            mem_known[(addr + i) & MEM_MASK] = 1'b1;
          end
          if (f3 == 3'd0 && addr == exit_addr_q) begin
            halt_q = 1'b1;
            exit_q = gpr[10][7:0];
          end
        end
      end
      rv32_pkg::OPC_BRANCH: begin
        wb = 1'b0;
        imm = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = $signed(a) >= $signed(b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: ok = 1'b0;
        endcase
        if (take) nxt = pc_q + imm;
      end
      rv32_pkg::OPC_LUI:   res = {inst[31:12], 12'b0};
      rv32_pkg::OPC_AUIPC: res = pc_q + {inst[31:12], 12'b0};
      rv32_pkg::OPC_JAL: begin
        imm = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
        res = nxt;
        nxt = pc_q + imm;
      end
      rv32_pkg::OPC_JALR: begin
        if (f3 != 3'd0) ok = 1'b0;
        else begin
          res = nxt;
          nxt = (a + immi) & ~32'd1;
        end
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      pc_q = pc_q + 4;
      return 1'b0;
    end
    if (wb && rd != 5'd0) gpr[rd] = res;
    pc_q = nxt;
    return 1'b1;
  endfunction

  function automatic rv32_pkg::out_item_t iss_predict(input rv32_pkg::in_item_t it);
    rv32_pkg::out_item_t o;
    o.illegal = 1'b0;
    if (it.op == rv32_pkg::OP_LOAD) begin
      mem[it.load_address] = it.load_byte;
      mem_known[it.load_address] = 1'b1;
    end else if (!halt_q) begin
      o.illegal = !iss_execute();
    end
    o.pc_after   = pc_q;
    o.halted     = halt_q;
    o.exit_value = exit_q;
    return o;
  endfunction

  // data bytes a step at pc will read, and whether it halts
  task automatic peek_step(output logic [31:0] addr, output int n, output bit halts);
    logic [31:0] inst;
    inst = mem_read(pc_q, 4);
    n = 0;
    halts = 1'b0;
    addr = gpr[inst[19:15]] + {{20{inst[31]}}, inst[31:20]};
    if (inst[6:0] == rv32_pkg::OPC_LOAD)
      case (inst[14:12])
        3'd0, 3'd4: n = 1;
        3'd1, 3'd5: n = 2;
        3'd2: n = 4;
        default: n = 0;
      endcase
    if (inst[6:0] == rv32_pkg::OPC_STORE && inst[14:12] == 3'd0)
      halts = (gpr[inst[19:15]] + {{20{inst[31]}}, inst[31:25], inst[11:7]}) == exit_addr_q;
  endtask

  task automatic send_item(input rv32_pkg::in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(iss_predict(it));
    n_items++;
  endtask

  task automatic send_load(input logic [31:0] a, input logic [7:0] v);
    rv32_pkg::in_item_t it;
    it.op = rv32_pkg::OP_LOAD;
    it.load_address = a[16:0];
    it.load_byte = v;
    send_item(it);
  endtask

  task automatic put_word(input logic [31:0] a, input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_load((a + i) & MEM_MASK, w[8*i +: 8]);
  endtask

  task automatic do_step(input bit halt_ok);
    logic [31:0]        addr;
    int                 n;
    bit                 halts;
    rv32_pkg::in_item_t it;
    for (int i = 0; i < 4; i++)
      if (!mem_known[(pc_q + i) & MEM_MASK])
        send_load((pc_q + i) & MEM_MASK, 8'($urandom));
    peek_step(addr, n, halts);
    for (int i = 0; i < n; i++)
      if (!mem_known[(addr + i) & MEM_MASK])
        send_load((addr + i) & MEM_MASK, 8'($urandom));
    if (halts && !halt_ok) put_word(pc_q, NOP);
    it = '0;
    it.op = rv32_pkg::OP_STEP;
    it.load_address = 17'($urandom);
    it.load_byte = 8'($urandom);
    send_item(it);
  endtask

  task automatic run_word(input logic [31:0] w, input bit halt_ok);
    put_word(pc_q, w);
    do_step(halt_ok);
  endtask

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32_pkg::OPC_JAL};
  endfunction

  function automatic logic [6:0] pick_f7();
    int k;
    k = $urandom_range(0, 9);
    return (k < 5) ? rv32_pkg::F7_BASE : (k < 9) ? rv32_pkg::F7_ALT : 7'($urandom);
  endfunction

  function automatic logic [31:0] rand_inst();
    logic [31:0] r;
    logic [12:0] bimm;
    logic [6:0]  opc;
    logic [2:0]  f3;
    r = $urandom;
    f3 = r[14:12];
    case ($urandom_range(0, 12))
      0, 1: r = {pick_f7(), r[24:7], rv32_pkg::OPC_REG};
      2, 3, 4: begin
        if (f3 == 3'd1 || f3 == 3'd5) r = {pick_f7(), r[24:7], rv32_pkg::OPC_IMM};
        else r[6:0] = rv32_pkg::OPC_IMM;
      end
      5: begin
        r[6:0] = rv32_pkg::OPC_LOAD;
        if ($urandom_range(0, 5) != 0) r[14:12] = 3'($urandom_range(0, 5)) == 3 ? 3'd4 : f3 % 3;
      end
      6: begin
        r[6:0] = rv32_pkg::OPC_STORE;
        if ($urandom_range(0, 5) != 0) r[14:12] = f3 % 3;
      end
      7: begin
        bimm = 13'($urandom);
        r = {bimm[12], bimm[10:5], r[24:12], bimm[4:1], bimm[11], rv32_pkg::OPC_BRANCH};
      end
      8:  r[6:0] = rv32_pkg::OPC_LUI;
      9:  r[6:0] = rv32_pkg::OPC_AUIPC;
      10: r[6:0] = rv32_pkg::OPC_JAL;
      11: begin
        r[6:0] = rv32_pkg::OPC_JALR;
        if ($urandom_range(0, 5) != 0) r[14:12] = 3'd0;
      end
      default: begin
        do opc = 7'($urandom); while (opc inside {rv32_pkg::OPC_REG, rv32_pkg::OPC_IMM,
          rv32_pkg::OPC_LOAD, rv32_pkg::OPC_STORE, rv32_pkg::OPC_BRANCH, rv32_pkg::OPC_LUI,
          rv32_pkg::OPC_AUIPC, rv32_pkg::OPC_JAL, rv32_pkg::OPC_JALR});
        r[6:0] = opc;
      end
    endcase
    return r;
  endfunction

  // long receiver hold-off
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      rx_block <= 1'b1;
    end else begin
      rx_block <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rv32_pkg::out_item_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = pending_results.pop_front();
          if (out_data.pc_after !== e.pc_after)
            report($sformatf("pc_after %h, want %h", out_data.pc_after, e.pc_after));
          if (out_data.halted !== e.halted)
            report($sformatf("halted %b, want %b", out_data.halted, e.halted));
          if (out_data.exit_value !== e.exit_value)
            report($sformatf("exit_value %h, want %h", out_data.exit_value, e.exit_value));
          if (out_data.illegal !== e.illegal)
            report($sformatf("illegal %b at pc %h, want %b", out_data.illegal, e.pc_after,
                             e.illegal));
        end
        rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (rx_block) begin
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] v, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= rv32_pkg::REG_EXIT;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_exit_address(input logic [31:0] v);
    logic [31:0] rd;
    apb_access(1'b1, v, rd);
    exit_addr_q = v;
    apb_access(1'b0, '0, rd);
    if (rd !== v) report($sformatf("exit_address reads %h, want %h", rd, v));
  endtask

  task automatic test_reset_value();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== rv32_pkg::EXIT_RESET) report($sformatf("exit_address reset %h", rd));
  endtask

  task automatic test_directed();
    send_load(32'h0, 8'h00);
    send_load(MEM_MASK, 8'hff);
    run_word({20'h80000, 5'd1, rv32_pkg::OPC_LUI}, 1'b0);
    run_word(enc_i(12'hfff, 5'd0, 3'd0, 5'd2, rv32_pkg::OPC_IMM), 1'b0);
    run_word({rv32_pkg::F7_ALT, 5'd2, 5'd1, 3'd5, 5'd3, rv32_pkg::OPC_REG}, 1'b0);
    run_word({7'h00, 5'd2, 5'd0, 3'd2, 5'd1, rv32_pkg::OPC_STORE}, 1'b0);
    run_word(enc_i(12'h001, 5'd0, 3'd1, 5'd4, rv32_pkg::OPC_JALR), 1'b0);
    run_word(enc_j(21'(-(pc_q + 4)), 5'd1), 1'b0);
    do_step(1'b0);
  endtask

  task automatic test_random(input int target, input logic [31:0] exit_at, input bit press);
    wait_idle();
    set_exit_address(exit_at);
    if (press) rx_hold = 120;
    while (n_items < target) begin
      case ($urandom_range(0, 9))
        0: do_step(1'b0);
        1: send_load($urandom, 8'($urandom));
        default: run_word(rand_inst(), 1'b0);
      endcase
    end
  endtask

  task automatic test_halt();
    wait_idle();
    set_exit_address(32'hffff_ffff);
    run_word(enc_i(12'hfff, 5'd0, 3'd0, 5'd1, rv32_pkg::OPC_IMM), 1'b0);
    run_word(enc_i(12'h1a5, 5'd0, 3'd0, 5'd10, rv32_pkg::OPC_IMM), 1'b0);
    run_word({7'h00, 5'd10, 5'd1, 3'd0, 5'd0, rv32_pkg::OPC_STORE}, 1'b1);
    do_step(1'b1);
    send_load($urandom, 8'($urandom));
    do_step(1'b1);
  endtask

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    pc_q = '0;
    halt_q = 1'b0;
    exit_q = '0;
    exit_addr_q = rv32_pkg::EXIT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random(450, 32'h0, 1'b0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_random(900, 32'hffff_ffff, 1'b1);
    tx_idle = 1'b0;
    test_random(1300, $urandom, 1'b0);
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    test_random(1750, rv32_pkg::EXIT_RESET, 1'b0);
    rx_idle = 1'b1;
    test_halt();
    wait_idle();
    if (n_errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== rv32i_instruction_executor_unit.f =====
design/rv32_pkg.sv
design/rv32_front.sv
design/rv32_back.sv
design/rv32i_instruction_executor_unit.sv
sim/tb_rv32i_instruction_executor_unit.sv
